### src/json_string_unescape_utf8_top_defines.svh
// Assertion macros used by the top-level RTL file of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define JSU_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("jsu assertion failed");
// Condition must never be true outside reset.
`define JSU_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("jsu forbidden condition seen");
`else
`define JSU_ASSERT(name, prop)
`define JSU_ASSERT_NEVER(name, cond)
`endif

`endif

### src/jsu_pkg.sv
// Package: types, constants and helpers of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  // Capacity register and limits
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] MAX_CAPACITY = 11'd1024;
  localparam logic [CAP_W-1:0] CAP_RESET    = 11'd32;

  // Register index, taken from the word address bit
  localparam logic REG_CAPACITY = 1'b0;

  // Results per request and result queue sizing
  localparam int MAX_RESULTS = 3;
  localparam int NRES_W      = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  // Error codes
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_ESC    = 3'd2;
  localparam logic [2:0] ERR_UNI    = 3'd3;
  localparam logic [2:0] ERR_LONG   = 3'd4;
  localparam logic [2:0] ERR_UNTERM = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // UTF-8 code point limits
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_STR  = 7'b0000010,
    MODE_ESC  = 7'b0000100,
    MODE_HEX0 = 7'b0001000,
    MODE_HEX1 = 7'b0010000,
    MODE_HEX2 = 7'b0100000,
    MODE_HEX3 = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [11:0]      hex_accum;
    logic [CAP_W-1:0] out_count;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_last;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    state_t                       nxt;
    logic [NRES_W-1:0]            n;
    res_t [MAX_RESULTS-1:0]       res;
  } step_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/jsu_step.sv
// Decode step: next state and up to three results for one text byte.
`default_nettype none

module jsu_step (
  input  wire logic [7:0]                 c,
  input  wire jsu_pkg::state_t            st,
  input  wire logic [jsu_pkg::CAP_W-1:0]  cap_eff,
  output jsu_pkg::step_t                  step
);
  import jsu_pkg::*;

  logic [4:0]  dig;
  logic        dig_ok;
  logic [3:0]  d;
  logic        emit;
  logic [NRES_W-1:0] emit_n;
  logic [7:0]  e0, e1, e2;
  logic [15:0] cp;
  logic        fin;
  logic [2:0]  fin_err;
  logic [CAP_W:0] need;

  assign dig    = hex_digit(c);
  assign dig_ok = dig[4];
  assign d      = dig[3:0];
  assign cp     = {st.hex_accum, d};

  always_comb begin
    step     = '0;
    step.nxt = st;
    emit     = 1'b0;
    emit_n   = '0;
    e0       = '0;
    e1       = '0;
    e2       = '0;
    fin      = 1'b0;
    fin_err  = ERR_OK;

    // Classify the byte by mode
    case (st.mode)
      MODE_STR: begin
        if (c == CH_NUL) begin
          fin     = 1'b1;
          fin_err = ERR_UNTERM;
        end else if (c == CH_QUOTE) begin
          step.n                 = NRES_W'(1);
          step.res[0].is_last    = 1'b1;
          step.res[0].error_code = ERR_OK;
          step.nxt.mode          = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          step.nxt.mode = MODE_ESC;
        end else begin
          emit   = 1'b1;
          emit_n = NRES_W'(1);
          e0     = c;
        end
      end
      MODE_ESC: begin
        case (c)
          CH_NUL: begin
            fin     = 1'b1;
            fin_err = ERR_UNTERM;
          end
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            emit   = 1'b1;
            emit_n = NRES_W'(1);
            e0     = c;
          end
          CH_LOW_N: begin
            emit   = 1'b1;
            emit_n = NRES_W'(1);
            e0     = CH_LF;
          end
          CH_LOW_T: begin
            emit   = 1'b1;
            emit_n = NRES_W'(1);
            e0     = CH_TAB;
          end
          CH_LOW_R: begin
            emit   = 1'b1;
            emit_n = NRES_W'(1);
            e0     = CH_CR;
          end
          CH_LOW_U: begin
            step.nxt.hex_accum = '0;
            step.nxt.mode      = MODE_HEX0;
          end
          default: begin
            fin     = 1'b1;
            fin_err = ERR_ESC;
          end
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
        if (!dig_ok) begin
          fin     = 1'b1;
          fin_err = ERR_UNI;
        end else begin
          step.nxt.hex_accum = {st.hex_accum[7:0], d};
          case (st.mode)
            MODE_HEX0: step.nxt.mode = MODE_HEX1;
            MODE_HEX1: step.nxt.mode = MODE_HEX2;
            default:   step.nxt.mode = MODE_HEX3;
          endcase
        end
      end
      MODE_HEX3: begin
        if (!dig_ok) begin
          fin     = 1'b1;
          fin_err = ERR_UNI;
        end else begin
          // Encode the code point as UTF-8
          step.nxt.hex_accum = '0;
          emit = 1'b1;
          if (cp < CP_ONE_LIMIT) begin
            emit_n = NRES_W'(1);
            e0     = cp[7:0];
          end else if (cp < CP_TWO_LIMIT) begin
            emit_n = NRES_W'(2);
            e0     = {3'b110, cp[10:6]};
            e1     = {2'b10, cp[5:0]};
          end else begin
            emit_n = NRES_W'(3);
            e0     = {4'b1110, cp[15:12]};
            e1     = {2'b10, cp[11:6]};
            e2     = {2'b10, cp[5:0]};
          end
        end
      end
      default: begin
        // Idle, and any stray encoding
        step.nxt.mode = MODE_IDLE;
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
          step.nxt.mode = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          step.nxt.mode      = MODE_STR;
          step.nxt.out_count = '0;
          step.nxt.hex_accum = '0;
        end else begin
          fin     = 1'b1;
          fin_err = ERR_QUOTE;
        end
      end
    endcase

    // Count the buffer use after this group
    need = {1'b0, st.out_count} + (CAP_W+1)'(emit_n);

    // Push a decoded group if it fits, else end the string
    if (emit) begin
      if (need < {1'b0, cap_eff}) begin
        step.n                 = emit_n;
        step.res[0].out_byte   = e0;
        step.res[0].has_byte   = 1'b1;
        step.res[1].out_byte   = e1;
        step.res[1].has_byte   = 1'b1;
        step.res[2].out_byte   = e2;
        step.res[2].has_byte   = 1'b1;
        step.nxt.out_count     = need[CAP_W-1:0];
        step.nxt.mode          = MODE_STR;
      end else begin
        fin     = 1'b1;
        fin_err = ERR_LONG;
      end
    end

    // Terminate with an error marker
    if (fin) begin
      step.res                = '0;
      step.n                  = NRES_W'(1);
      step.res[0].is_last     = 1'b1;
      step.res[0].error_code  = fin_err;
      step.nxt.mode           = MODE_IDLE;
      step.nxt.hex_accum      = '0;
    end
  end

endmodule

`default_nettype wire

### src/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 encoding of \u escapes.
//
// Input channel: text_byte with in_valid/in_ready, one JSON text byte per request.
// Output channel: out_byte, has_byte, is_last, error_code with out_valid/out_ready;
// each request yields zero to three results (UTF-8 bytes, a closing marker or an
// error marker, is_last set on the marker).
// Config: APB-style port, register capacity at address 0 (reset 32, saturates at
// 1024); the user must see that it is written only while the block is idle;
// the block itself does not enforce this. A request passes the input register,
// then is decoded into a four-entry result queue whose head drives the output.
// Throughput: one request per cycle while each yields at most one result and the
// receiver holds out_ready high; the output drains one queue entry per cycle
// while out_ready is high, a request producing n bytes using n entries. Input is
// taken whenever the queue keeps room for three results.
// Receiver stall: results wait in the queue; input stalls once the queue is
// more than one entry deep.
// Reset: synchronous; parser idle awaiting a quote, queue empty, capacity 32.
`default_nettype none

`include "json_string_unescape_utf8_top_defines.svh"

module json_string_unescape_utf8_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Text input
  input  wire logic [7:0]  text_byte,
  input  wire logic        in_valid,
  output logic             in_ready,
  // Decoded output
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             is_last,
  output logic [2:0]       error_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import jsu_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] cap_eff;
  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_go;
  state_t           st;
  step_t            step;
  res_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] after_pop;
  logic             pop;
  logic             room;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign cap_eff = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;

  // Queue occupancy and flow control
  assign pop       = out_valid && out_ready;
  assign after_pop = count - CNT_W'(pop);
  assign room      = after_pop <= CNT_W'(FIFO_DEPTH - MAX_RESULTS);
  assign s1_go     = s1_valid && room;
  assign in_ready  = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_byte <= text_byte;
    end
  end

  // Decode one byte
  jsu_step u_step (
    .c       (s1_byte),
    .st      (st),
    .cap_eff (cap_eff),
    .step    (step)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode      <= MODE_IDLE;
      st.hex_accum <= '0;
      st.out_count <= '0;
    end else if (s1_go) begin
      st <= step.nxt;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (s1_go && NRES_W'(i) < step.n) begin
        fifo[wr_ptr + PTR_W'(i)] <= step.res[i];
      end
    end
  end

  assign count_next = after_pop + (s1_go ? CNT_W'(step.n) : CNT_W'(0));

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (s1_go) begin
        wr_ptr <= wr_ptr + PTR_W'(step.n);
      end
    end
  end

  // Head of queue drives the output
  assign out_valid  = count != '0;
  assign out_byte   = fifo[rd_ptr].out_byte;
  assign has_byte   = fifo[rd_ptr].has_byte;
  assign is_last    = fifo[rd_ptr].is_last;
  assign error_code = fifo[rd_ptr].error_code;

  // Checks
  `JSU_ASSERT_NEVER(a_count_bound, count > CNT_W'(FIFO_DEPTH))
  `JSU_ASSERT(a_last_to_idle, (s1_go && step.res[0].is_last) |=> st.mode == MODE_IDLE)
  `JSU_ASSERT_NEVER(a_out_count_bound, st.out_count >= MAX_CAPACITY)
  `JSU_ASSERT(a_count_hold, (!s1_go && !pop) |=> count == $past(count))

endmodule

`default_nettype wire

### dv/tb_json_string_unescape_utf8_top.sv
// Testbench for the JSON string unescaper: directed and random text checked against a predictor.
module tb_json_string_unescape_utf8_top;
  import jsu_pkg::*;

  localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 35;
  localparam int TAIL_CYCLES   = 8;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_LONG} stall_t;

  // DUT signals; the inputs are driven to known values from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  text_byte = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  out_byte;
  logic        has_byte;
  logic        is_last;
  logic [2:0]  error_code;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'b000;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [CAP_W-1:0] cap_reg = CAP_RESET;
  mode_t            parse_mode = MODE_IDLE;
  logic [11:0]      hex_acc = 12'h000;
  logic [CAP_W-1:0] out_total = '0;
  res_t             utf8_results_q[$];

  // Stimulus control
  stall_t      stall_mode = STALL_NONE;
  int unsigned ready_tick = 0;
  bit          sender_gaps = 1'b0;
  int          burst_left = 0;
  int          fail_count = 0;
  logic [7:0]  text_q[$];

  json_string_unescape_utf8_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_byte  (text_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .is_last    (is_last),
    .error_code (error_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return {is_hex, value} for one text byte
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'b0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic hb, input logic last,
                                      input logic [2:0] err);
    res_t r;
    r.out_byte   = b;
    r.has_byte   = hb;
    r.is_last    = last;
    r.error_code = err;
    utf8_results_q.push_back(r);
  endfunction

  // End the string with a marker and drop back to idle
  function automatic void close_string(input logic [2:0] err);
    push_result(8'h00, 1'b0, 1'b1, err);
    parse_mode = MODE_IDLE;
    hex_acc    = 12'h000;
  endfunction

  // Emit a whole group of decoded bytes, or refuse it when it does not fit
  function automatic void put_group(input int n, input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2);
    logic [CAP_W-1:0] limit;
    limit = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : cap_reg;
    if (int'(out_total) + n >= int'(limit)) begin
      close_string(ERR_LONG);
    end else begin
      push_result(b0, 1'b1, 1'b0, ERR_OK);
      if (n > 1) push_result(b1, 1'b1, 1'b0, ERR_OK);
      if (n > 2) push_result(b2, 1'b1, 1'b0, ERR_OK);
      out_total  = out_total + CAP_W'(n);
      parse_mode = MODE_STR;
    end
  endfunction

  function automatic void encode_code_point(input logic [15:0] v);
    if (v < CP_ONE_LIMIT) begin
      put_group(1, v[7:0], 8'h00, 8'h00);
    end else if (v < CP_TWO_LIMIT) begin
      put_group(2, {3'b110, v[10:6]}, {2'b10, v[5:0]}, 8'h00);
    end else begin
      put_group(3, {4'b1110, v[15:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]});
    end
  endfunction

  function automatic void decode_text_byte(input logic [7:0] c);
    logic [4:0] nib;
    nib = nibble_of(c);
    case (parse_mode)
      MODE_STR: begin
        if (c == CH_NUL) close_string(ERR_UNTERM);
        else if (c == CH_QUOTE) begin
          push_result(8'h00, 1'b0, 1'b1, ERR_OK);
          parse_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) parse_mode = MODE_ESC;
        else put_group(1, c, 8'h00, 8'h00);
      end
      MODE_ESC: begin
        case (c)
          CH_NUL:                       close_string(ERR_UNTERM);
          CH_QUOTE, CH_BSLASH, CH_SLASH: put_group(1, c, 8'h00, 8'h00);
          CH_LOW_N:                     put_group(1, CH_LF, 8'h00, 8'h00);
          CH_LOW_T:                     put_group(1, CH_TAB, 8'h00, 8'h00);
          CH_LOW_R:                     put_group(1, CH_CR, 8'h00, 8'h00);
          CH_LOW_U: begin
            hex_acc    = 12'h000;
            parse_mode = MODE_HEX0;
          end
          default:                      close_string(ERR_ESC);
        endcase
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!nib[4]) begin
          close_string(ERR_UNI);
        end else if (parse_mode == MODE_HEX3) begin
          logic [15:0] cp;
          cp      = {hex_acc, nib[3:0]};
          hex_acc = 12'h000;
          encode_code_point(cp);
        end else begin
          hex_acc = {hex_acc[7:0], nib[3:0]};
          case (parse_mode)
            MODE_HEX0: parse_mode = MODE_HEX1;
            MODE_HEX1: parse_mode = MODE_HEX2;
            default:   parse_mode = MODE_HEX3;
          endcase
        end
      end
      default: begin
        // Idle: skip whitespace, open on a quote, reject anything else
        parse_mode = MODE_IDLE;
        if (c == CH_QUOTE) begin
          parse_mode = MODE_STR;
          out_total  = '0;
          hex_acc    = 12'h000;
        end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
          close_string(ERR_QUOTE);
        end
      end
    endcase
  endfunction

  // Predict on every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) decode_text_byte(text_byte);
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (utf8_results_q.size() == 0) begin
        $error("result with none expected: out_byte 0x%0h has_byte %0b is_last %0b error_code %0d",
               out_byte, has_byte, is_last, error_code);
        fail_count++;
      end else begin
        want = utf8_results_q.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("has_byte", want.has_byte, has_byte);
        check_field("is_last", want.is_last, is_last);
        check_field("error_code", want.error_code, error_code);
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    case (stall_mode)
      STALL_NONE:   out_ready <= 1'b1;
      STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      STALL_SPARSE: out_ready <= (ready_tick % 5 == 0);
      default:      out_ready <= ready_tick[5] & ~ready_tick[0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one text byte, hold it until accepted, then maybe pause the sender
  task automatic send_byte(input logic [7:0] b);
    text_byte <= b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) send_byte(text_q[i]);
  endtask

  // Drop valid, let the last request reach the predictor, wait for every expected
  // result, then let the pipeline empty
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (utf8_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    paddr   <= CAPACITY_ADDR;
    pwdata  <= 32'(value);
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_reg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random text
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return 8'h30 + 8'(d);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
  endfunction

  // Build one chunk of text: mostly well-formed strings, some noise and broken strings
  task automatic compose_text(output int counted);
    int          kind;
    bit          broken;
    logic [7:0]  b;
    logic [4:0]  nib;
    logic [15:0] cp;
    text_q = {};
    broken = 1'b0;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(CH_SPACE);
        1:       text_q.push_back(CH_TAB);
        2:       text_q.push_back(CH_LF);
        default: text_q.push_back(CH_CR);
      endcase
    end
    counted = -text_q.size();
    if ($urandom_range(0, 9) == 0) begin
      // Noise while idle
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      text_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 12)) begin
        if (!broken) begin
          kind = $urandom_range(0, 9);
          if (kind <= 4) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
            text_q.push_back(b);
          end else if (kind <= 6) begin
            text_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 5))
              0:       text_q.push_back(CH_QUOTE);
              1:       text_q.push_back(CH_BSLASH);
              2:       text_q.push_back(CH_SLASH);
              3:       text_q.push_back(CH_LOW_N);
              4:       text_q.push_back(CH_LOW_T);
              default: text_q.push_back(CH_LOW_R);
            endcase
          end else if (kind <= 8) begin
            case ($urandom_range(0, 2))
              0:       cp = 16'($urandom_range(0, 'h7F));
              1:       cp = 16'($urandom_range('h80, 'h7FF));
              default: cp = 16'($urandom_range('h800, 'hFFFF));
            endcase
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_LOW_U);
            for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(cp[4*i +: 4]));
          end else begin
            broken = 1'b1;
            case ($urandom_range(0, 3))
              0: begin
                // Unknown escape letter
                do b = 8'($urandom_range(1, 255));
                while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_N, CH_LOW_T,
                                 CH_LOW_R, CH_LOW_U});
                text_q.push_back(CH_BSLASH);
                text_q.push_back(b);
              end
              1: text_q.push_back(CH_NUL);
              2: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_NUL);
              end
              default: begin
                // Non-hex byte somewhere in a unicode escape
                text_q.push_back(CH_BSLASH);
                text_q.push_back(CH_LOW_U);
                repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
                do begin
                  b   = 8'($urandom_range(0, 255));
                  nib = nibble_of(b);
                end while (nib[4]);
                text_q.push_back(b);
              end
            endcase
          end
        end
      end
      if (!broken && $urandom_range(0, 19) != 0) text_q.push_back(CH_QUOTE);
    end
    counted += text_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Whitespace is skipped while idle; anything but a quote is rejected
  task automatic test_idle_bytes();
    stall_mode  = STALL_RANDOM;
    sender_gaps = 1'b1;
    send_byte(CH_SPACE);
    send_byte(CH_TAB);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte("x");
    send_byte(CH_NUL);
    send_byte(8'hFF);
  endtask

  // Plain bytes at the extremes and every simple escape, then an unknown one
  task automatic test_escapes();
    send_str("\"a\\\"\\\\\\/\\n\\t\\r");
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(CH_QUOTE);
    send_str("\"\\q");
  endtask

  // One, two and three byte encodings at their edges, a lone surrogate, mixed case
  task automatic test_unicode();
    send_str("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uD83D\\uFfFf\"");
  endtask

  // NUL inside a string, after a backslash and as a hex digit; non-hex digit
  task automatic test_string_errors();
    send_str("\"a");
    send_byte(CH_NUL);
    send_str("\"\\");
    send_byte(CH_NUL);
    send_str("\"\\u1");
    send_byte(CH_NUL);
    send_str("\"\\u12g");
  endtask

  // Refuse whole groups at the buffer limit, including zero and saturated capacity
  task automatic test_capacity_limit();
    wait_until_drained();
    write_capacity(11'd0);
    send_str("\"a");
    wait_until_drained();
    write_capacity(11'd1);
    send_str("\"\"\"a");
    wait_until_drained();
    write_capacity(11'd2);
    send_str("\"ab");
    wait_until_drained();
    write_capacity(11'd3);
    send_str("\"\\u00e9\"\"\\u0800");
    wait_until_drained();
    write_capacity(11'd4);
    send_str("\"\\u20AC\"");
    // Above the limit the capacity saturates, so a short string passes untouched
    wait_until_drained();
    write_capacity(11'd2047);
    stall_mode  = STALL_NONE;
    sender_gaps = 1'b0;
    send_byte(CH_QUOTE);
    send_str("zz\"");
  endtask

  // Random text over several capacities and stall patterns
  task automatic test_random_text();
    int               phase_items;
    int               counted;
    logic [CAP_W-1:0] cap;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       cap = MAX_CAPACITY;
        1:       cap = 11'd12;
        2:       cap = 11'd2047;
        3:       cap = 11'd5;
        4:       cap = CAP_RESET;
        default: cap = CAP_W'($urandom_range(2, 64));
      endcase
      wait_until_drained();
      write_capacity(cap);
      stall_mode  = stall_t'(p % 4);
      sender_gaps = (p % 3 != 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        compose_text(counted);
        send_text_q();
        phase_items += counted;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_bytes();
    test_escapes();
    test_unicode();
    test_string_errors();
    test_capacity_limit();
    test_random_text();
    wait_until_drained();
    if (fail_count == 0 && utf8_results_q.size() == 0) begin
      $display("tb_json_string_unescape_utf8_top: PASS");
    end else begin
      $display("tb_json_string_unescape_utf8_top: FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("tb_json_string_unescape_utf8_top: FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/jsu_pkg.sv
src/jsu_step.sv
src/json_string_unescape_utf8_top.sv
dv/tb_json_string_unescape_utf8_top.sv
